// ===== rtl/bsr_pkg.sv =====
`timescale 1ns / 1ps

package bsr_pkg;

    localparam int MAX_IMAGE_DIM = 4096;
    localparam int DIM_W         = 13;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ORIGIN_X      = 2'd2;
    localparam logic [1:0] REG_ORIGIN_Y      = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS
    } phase_t;

    typedef struct packed {
        logic [12:0]        screen_width;
        logic [12:0]        screen_height;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
    } cfg_t;

    // one unit of work handed from the parser to the pixel generator
    typedef struct packed {
        logic        mono;
        logic [15:0] data;
        logic [15:0] pal0;
        logic [15:0] pal1;
        logic [13:0] col;
        logic [12:0] row;
        logic [3:0]  cnt;
        logic        done;
        logic        status;
    } work_t;

    // screen size clamped to the coordinate range
    function automatic logic [12:0] eff_dim(input logic [12:0] v);
        return (v > 13'd4096) ? 13'd4096 : v;
    endfunction

endpackage

// ===== rtl/bsr_queue.sv =====
`timescale 1ns / 1ps

module bsr_queue
    import bsr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output work_t pop_data
);

    work_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/bsr_front.sv =====
`timescale 1ns / 1ps

module bsr_front
    import bsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    input  logic       q_full,
    output logic       in_ready,
    output logic       push,
    output work_t      push_data
);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] hlen_reg, hlen_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic        bu_reg, bu_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [31:0] palcnt_reg, palcnt_next;
    logic [15:0] pal0_reg, pal0_next;
    logic [15:0] pal1_reg, pal1_next;
    logic [12:0] row_reg, row_next;
    logic [14:0] idx_reg, idx_next;
    logic [12:0] pcol_reg, pcol_next;
    logic [15:0] part_reg, part_next;
    logic        fin_reg, fin_next;
    logic [1:0]  mod3_reg, mod3_next;

    logic        accept;
    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        logic [31:0]        acc;
        logic [31:0]        mag;
        logic [32:0]        pal_start;
        logic [33:0]        pal_end;
        logic [33:0]        need;
        logic [33:0]        hdr_next;
        logic [33:0]        diff;
        logic [3:0]         ent4;
        logic               end_hdr;
        logic signed [17:0] ox;
        logic signed [17:0] oy;
        logic signed [17:0] ew;
        logic signed [17:0] eh;
        logic [15:0]        rs24;
        logic [13:0]        rs1;
        logic [15:0]        rsize;
        logic [17:0]        rem;
        logic [13:0]        row_inc;
        logic [12:0]        img_row;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        offset_next = offset_reg;
        hlen_next   = hlen_reg;
        width_next  = width_reg;
        height_next = height_reg;
        bu_next     = bu_reg;
        bpp_next    = bpp_reg;
        palcnt_next = palcnt_reg;
        pal0_next   = pal0_reg;
        pal1_next   = pal1_reg;
        row_next    = row_reg;
        idx_next    = idx_reg;
        pcol_next   = pcol_reg;
        part_next   = part_reg;
        fin_next    = fin_reg;
        mod3_next   = mod3_reg;
        push        = 1'b0;
        push_data   = '0;
        end_hdr     = 1'b0;
        hdr_next    = '0;
        need        = '0;
        acc         = '0;
        mag         = '0;
        diff        = '0;
        rem         = '0;
        row_inc     = '0;
        rsize       = '0;

        // new file restarts the parser
        if (in_start)
        begin
            phase_next  = PH_HEADER;
            pos_next    = '0;
            acc_next    = '0;
            offset_next = '0;
            hlen_next   = '0;
            width_next  = '0;
            height_next = '0;
            bu_next     = 1'b1;
            bpp_next    = '0;
            palcnt_next = '0;
            pal0_next   = '0;
            pal1_next   = '0;
            row_next    = '0;
            idx_next    = '0;
            pcol_next   = '0;
            part_next   = '0;
            fin_next    = 1'b0;
            mod3_next   = '0;
        end

        ox = 18'(cfg.origin_x);
        oy = 18'(cfg.origin_y);
        ew = $signed({5'd0, eff_dim(cfg.screen_width)});
        eh = $signed({5'd0, eff_dim(cfg.screen_height)});

        // palette placement follows the header length
        if (hlen_next <= 32'd12)
        begin
            pal_start = 33'd30;
        end
        else if ({1'b0, hlen_next} + 33'd14 < 33'd54)
        begin
            pal_start = 33'd54;
        end
        else
        begin
            pal_start = {1'b0, hlen_next} + 33'd14;
        end
        ent4    = (palcnt_next == 32'd1) ? 4'd4 : 4'd8;
        pal_end = {1'b0, pal_start} + {30'd0, ent4};

        rs24    = ({3'd0, width_next} + {2'd0, width_next, 1'b0} + 16'd3) & 16'hFFFC;
        rs1     = (({1'b0, width_next} + 14'd31) >> 3) & 14'h3FFC;
        img_row = bu_next ? (height_next - 13'd1 - row_next) : row_next;

        if (accept && !fin_next)
        begin
            case (phase_next)
                PH_HEADER:
                begin
                    acc      = {in_byte, acc_next[31:8]};
                    acc_next = acc;
                    pos_next = pos_next + 32'd1;
                    case (pos_reg[5:0] & {6{!in_start}})
                        6'd0:
                        begin
                            if (ox >= ew || oy >= eh)
                            begin
                                fin_next       = 1'b1;
                                push           = 1'b1;
                                push_data.done = 1'b1;
                            end
                        end
                        6'd1:
                        begin
                            if (acc[31:16] != BMP_SIGNATURE)
                            begin
                                fin_next         = 1'b1;
                                push             = 1'b1;
                                push_data.done   = 1'b1;
                                push_data.status = 1'b1;
                            end
                        end
                        6'd13: offset_next = acc;
                        6'd17: hlen_next = acc;
                        6'd21:
                        begin
                            if (acc < 32'd1 || acc > 32'(MAX_IMAGE_DIM))
                            begin
                                fin_next         = 1'b1;
                                push             = 1'b1;
                                push_data.done   = 1'b1;
                                push_data.status = 1'b1;
                            end
                            width_next = acc[12:0];
                        end
                        6'd25:
                        begin
                            mag     = acc;
                            bu_next = 1'b1;
                            if (acc[31])
                            begin
                                mag     = ~acc + 32'd1;
                                bu_next = 1'b0;
                            end
                            if (mag < 32'd1 || mag > 32'(MAX_IMAGE_DIM))
                            begin
                                fin_next         = 1'b1;
                                push             = 1'b1;
                                push_data.done   = 1'b1;
                                push_data.status = 1'b1;
                            end
                            height_next = mag[12:0];
                        end
                        6'd27:
                        begin
                            if (acc[31:16] != 16'd1)
                            begin
                                fin_next         = 1'b1;
                                push             = 1'b1;
                                push_data.done   = 1'b1;
                                push_data.status = 1'b1;
                            end
                        end
                        6'd29:
                        begin
                            bpp_next = acc[31:16];
                            if (bpp_next != 16'd24 && bpp_next != 16'd1)
                            begin
                                fin_next         = 1'b1;
                                push             = 1'b1;
                                push_data.done   = 1'b1;
                                push_data.status = 1'b1;
                            end
                            else if (hlen_next <= 32'd12)
                            begin
                                end_hdr  = 1'b1;
                                hdr_next = 34'd30;
                            end
                        end
                        6'd33:
                        begin
                            if (acc != 32'd0)
                            begin
                                fin_next         = 1'b1;
                                push             = 1'b1;
                                push_data.done   = 1'b1;
                                push_data.status = 1'b1;
                            end
                        end
                        6'd49: palcnt_next = acc;
                        6'd53:
                        begin
                            end_hdr  = 1'b1;
                            hdr_next = 34'd54;
                        end
                        default: ;
                    endcase

                    // end of header: clipping and offset checks
                    if (end_hdr)
                    begin
                        need = hdr_next;
                        if (bpp_next == 16'd1 && pal_end > need)
                        begin
                            need = pal_end;
                        end
                        if (!(ox < ew && ox + $signed({5'd0, width_next}) > 18'sd0 &&
                              oy < eh && oy + $signed({5'd0, height_next}) > 18'sd0))
                        begin
                            fin_next       = 1'b1;
                            push           = 1'b1;
                            push_data.done = 1'b1;
                        end
                        else if ({2'd0, offset_next} < need)
                        begin
                            fin_next         = 1'b1;
                            push             = 1'b1;
                            push_data.done   = 1'b1;
                            push_data.status = 1'b1;
                        end
                        else
                        begin
                            phase_next = ({2'd0, offset_next} == hdr_next) ? PH_PIXELS
                                                                           : PH_SKIP;
                        end
                    end
                end

                PH_SKIP:
                begin
                    // capture palette entries 0 and 1 on the way to the data
                    diff = {2'd0, pos_next} - {1'b0, pal_start};
                    if (bpp_next == 16'd1 && {2'd0, pos_next} >= {1'b0, pal_start} &&
                        {2'd0, pos_next} < pal_end)
                    begin
                        case (diff[1:0])
                            2'd0: part_next = {11'd0, in_byte[7:3]};
                            2'd1: part_next = part_next | {5'd0, in_byte[7:2], 5'd0};
                            2'd2:
                            begin
                                if (diff[2])
                                begin
                                    pal1_next = part_next | {in_byte[7:3], 11'd0};
                                end
                                else
                                begin
                                    pal0_next = part_next | {in_byte[7:3], 11'd0};
                                end
                            end
                            default: ;
                        endcase
                    end
                    pos_next = pos_next + 32'd1;
                    if (pos_next == offset_next)
                    begin
                        phase_next = PH_PIXELS;
                    end
                end

                default:
                begin
                    push_data.row  = img_row;
                    push_data.pal0 = pal0_next;
                    push_data.pal1 = pal1_next;
                    if (bpp_next == 16'd24)
                    begin
                        rsize = rs24;
                        if ({1'b0, idx_next} < {3'd0, width_next} + {2'd0, width_next, 1'b0})
                        begin
                            case (mod3_next)
                                2'd0: part_next = {11'd0, in_byte[7:3]};
                                2'd1: part_next = part_next | {5'd0, in_byte[7:2], 5'd0};
                                default:
                                begin
                                    push           = 1'b1;
                                    push_data.data = part_next | {in_byte[7:3], 11'd0};
                                    push_data.col  = {1'b0, pcol_next};
                                    push_data.cnt  = 4'd1;
                                    pcol_next      = pcol_next + 13'd1;
                                end
                            endcase
                            mod3_next = (mod3_next == 2'd2) ? 2'd0 : mod3_next + 2'd1;
                        end
                    end
                    else
                    begin
                        rsize = {2'd0, rs1};
                        if ({1'b0, idx_next} < 16'(({1'b0, width_next} + 14'd7) >> 3))
                        begin
                            rem            = {5'd0, width_next} - {idx_next, 3'b000};
                            push           = 1'b1;
                            push_data.mono = 1'b1;
                            push_data.data = {8'd0, in_byte};
                            push_data.col  = {idx_next[10:0], 3'b000};
                            push_data.cnt  = (rem >= 18'd8) ? 4'd8 : rem[3:0];
                        end
                    end
                    // row end, and end of data after the last row
                    if ({1'b0, idx_next} + 16'd1 >= rsize)
                    begin
                        idx_next  = '0;
                        pcol_next = '0;
                        mod3_next = '0;
                        row_inc   = {1'b0, row_next} + 14'd1;
                        row_next  = row_inc[12:0];
                        if (row_inc >= {1'b0, height_next})
                        begin
                            fin_next       = 1'b1;
                            push           = 1'b1;
                            push_data.done = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_next + 15'd1;
                    end
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            acc_reg    <= '0;
            offset_reg <= '0;
            hlen_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            bu_reg     <= 1'b1;
            bpp_reg    <= '0;
            palcnt_reg <= '0;
            pal0_reg   <= '0;
            pal1_reg   <= '0;
            row_reg    <= '0;
            idx_reg    <= '0;
            pcol_reg   <= '0;
            part_reg   <= '0;
            fin_reg    <= 1'b0;
            mod3_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            offset_reg <= offset_next;
            hlen_reg   <= hlen_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            bu_reg     <= bu_next;
            bpp_reg    <= bpp_next;
            palcnt_reg <= palcnt_next;
            pal0_reg   <= pal0_next;
            pal1_reg   <= pal1_next;
            row_reg    <= row_next;
            idx_reg    <= idx_next;
            pcol_reg   <= pcol_next;
            part_reg   <= part_next;
            fin_reg    <= fin_next;
            mod3_reg   <= mod3_next;
        end
    end

endmodule

// ===== rtl/bsr_back.sv =====
`timescale 1ns / 1ps

module bsr_back
    import bsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  work_t       q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_color,
    output logic [11:0] out_x,
    output logic [11:0] out_y,
    output logic        out_pixel,
    output logic        out_done,
    output logic        out_status
);

    work_t       cur_reg;
    logic        cur_valid_reg;
    logic [3:0]  i_reg;
    logic        ov_reg;
    logic [15:0] color_reg;
    logic [11:0] x_reg;
    logic [11:0] y_reg;
    logic        pix_reg;
    logic        done_reg;
    logic        st_reg;

    logic               can_write;
    logic               in_pixels;
    logic               visible;
    logic               step;
    logic               write;
    logic               retire;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [15:0]        color;
    logic [2:0]         bitsel;

    assign can_write = !ov_reg || out_ready;
    assign in_pixels = i_reg < cur_reg.cnt;
    assign x = 18'(cfg.origin_x) + $signed({4'd0, cur_reg.col + {10'd0, i_reg}});
    assign y = 18'(cfg.origin_y) + $signed({5'd0, cur_reg.row});
    assign visible = (x >= 18'sd0) && (y >= 18'sd0) &&
                     (x < $signed({5'd0, eff_dim(cfg.screen_width)})) &&
                     (y < $signed({5'd0, eff_dim(cfg.screen_height)}));
    assign bitsel = 3'd7 - i_reg[2:0];
    assign color  = !cur_reg.mono ? cur_reg.data :
                    (cur_reg.data[bitsel] ? cur_reg.pal1 : cur_reg.pal0);

    // one pixel or the closing status per cycle while the output is not stalled
    always_comb
    begin
        step   = 1'b0;
        write  = 1'b0;
        retire = 1'b0;
        if (cur_valid_reg)
        begin
            if (in_pixels)
            begin
                step   = !visible || can_write;
                write  = visible && can_write;
                retire = step && (i_reg + 4'd1 >= cur_reg.cnt) && !cur_reg.done;
            end
            else
            begin
                step   = can_write;
                write  = can_write;
                retire = can_write;
            end
        end
    end

    assign q_pop = !q_empty && (!cur_valid_reg || retire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            i_reg         <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                i_reg         <= '0;
            end
            else if (retire)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (step && in_pixels)
            begin
                i_reg <= i_reg + 4'd1;
            end
            if (write)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // work entry and output beat
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (write)
        begin
            pix_reg   <= in_pixels;
            color_reg <= in_pixels ? color : 16'd0;
            x_reg     <= in_pixels ? x[11:0] : 12'd0;
            y_reg     <= in_pixels ? y[11:0] : 12'd0;
            done_reg  <= !in_pixels;
            st_reg    <= !in_pixels && cur_reg.status;
        end
    end

    assign out_valid  = ov_reg;
    assign out_color  = color_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_pixel  = pix_reg;
    assign out_done   = done_reg;
    assign out_status = st_reg;

endmodule

// ===== rtl/bmp_stream_to_rgb565_top.sv =====
`timescale 1ns / 1ps

// BMP byte stream to RGB565 pixel stream. One file byte is taken per cycle
// while the four-entry work queue has room; the parser never stalls on its
// own. The pixel generator takes one step per beat of 24-bit data, per status
// and per pixel of a byte of 1-bit data, up to eight per byte, which sets the
// sustained rate for monochrome images. Output beats: tdata holds colour,
// column and row, tuser holds is_pixel and status, and tlast marks the one
// closing status beat of each file. Clipped pixels are dropped without a
// beat. Configuration is to be written only while idle (not enforced here).
module bmp_stream_to_rgb565_top
    import bsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_color[15:0], screen_x[27:16], screen_y[39:28]
    output logic        m_tlast,   // done_res
    output logic [1:0]  m_tuser,   // is_pixel[0], status[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    work_t push_data;
    work_t pop_data;
    logic [15:0] color;
    logic [11:0] sx;
    logic [11:0] sy;
    logic        pix;
    logic        st;

    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= 13'd240;
            cfg_reg.screen_height <= 13'd320;
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= pwdata[12:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[12:0];
                REG_ORIGIN_X:      cfg_reg.origin_x      <= pwdata[15:0];
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_SCREEN_WIDTH:  prdata = {19'd0, cfg_reg.screen_width};
            REG_SCREEN_HEIGHT: prdata = {19'd0, cfg_reg.screen_height};
            REG_ORIGIN_X:      prdata = {16'd0, cfg_reg.origin_x};
            REG_ORIGIN_Y:      prdata = {16'd0, cfg_reg.origin_y};
            default:           prdata = '0;
        endcase
    end

    bsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (push),
        .push_data (push_data)
    );

    bsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    bsr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .q_pop      (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_color  (color),
        .out_x      (sx),
        .out_y      (sy),
        .out_pixel  (pix),
        .out_done   (m_tlast),
        .out_status (st)
    );

    assign m_tdata = {sy, sx, color};
    assign m_tuser = {st, pix};

endmodule
